// File: src/itoa_pkg.sv
// Shared types, constants and helpers for the integer to ASCII formatter.
`default_nettype none

package itoa_pkg;

    // Conversion modes as they arrive on the input tuser
    typedef enum logic [1:0] {
        REQ_UDEC = 2'd0,
        REQ_HEX  = 2'd1,
        REQ_SDEC = 2'd2,
        REQ_NONE = 2'd3
    } req_type_t;

    // Digit storage sizing
    localparam int MAX_DIGITS = 10;
    localparam int CNT_W      = $clog2(MAX_DIGITS + 1);

    // Job queue sizing
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Characters
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_A     = 8'h61;

    // Reciprocal of ten: q = (x * RECIP10) >> RECIP_SHIFT is exact for 32-bit x
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;
    localparam int          QUOT_W      = 64 - RECIP_SHIFT;

    typedef logic [MAX_DIGITS-1:0][3:0] digit_vec_t;

    // Classified item between front and converter
    typedef struct packed {
        logic [31:0] mag;
        logic        hex;
        logic        neg;
    } job_t;

    // Finished digit string from converter to emitter, most significant in slot 0
    typedef struct packed {
        digit_vec_t         digits;
        logic [CNT_W-1:0]   ndig;
        logic               neg;
    } conv_t;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_DONE
    } conv_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SIGN,
        EM_DIGITS
    } emit_state_t;

    // Map a digit value to its lower-case glyph
    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] ch;
        if (d < 4'd10) begin
            ch = CHAR_ZERO + {4'd0, d};
        end
        else begin
            ch = CHAR_A + {4'd0, d} - 8'd10;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

// File: src/integer_to_ascii_formatter.sv
// Top level of the integer to ASCII formatter.
`default_nettype none

// Converts a 32-bit value to ASCII (unsigned decimal, lower-case hex, or signed
// decimal selected by s_axis_tuser) and streams the characters most significant
// digit first, one per m_axis transaction, tlast on the final one; mode 3 is
// consumed and produces nothing. A two-entry job queue separates input
// acceptance from conversion. The converter makes one digit per cycle with a
// reciprocal multiply (decimal) or a shift (hex); the emitter then sends one
// character per cycle from the output register, when the output side does not
// stall, while the converter already works on the next number.
module integer_to_ascii_formatter
    import itoa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] req_type
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] ascii_char
    output logic             m_axis_tlast
);

    logic  push;
    job_t  push_data;
    logic  full;
    logic  job_pop;
    logic  job_valid;
    job_t  job_data;
    logic  res_valid;
    conv_t res_data;
    logic  res_ready;

    itoa_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_data     (push_data),
        .full          (full)
    );

    itoa_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (job_pop),
        .pop_valid (job_valid),
        .pop_data  (job_data)
    );

    itoa_conv u_conv (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_data  (job_data),
        .job_pop   (job_pop),
        .res_valid (res_valid),
        .res_data  (res_data),
        .res_ready (res_ready)
    );

    itoa_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (res_valid),
        .in_data       (res_data),
        .in_ready      (res_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// File: src/itoa_fifo.sv
// Short job queue between the classifying front and the converter.
`default_nettype none

module itoa_fifo
    import itoa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire job_t  push_data,
    output logic       full,
    input  wire logic  pop,
    output logic       pop_valid,
    output job_t       pop_data
);

    job_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    // Qualify requests against occupancy
    assign full      = (count_reg == QCNT_W'(QDEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the entry
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: src/itoa_front.sv
// Input side: accepts values, decodes the mode, and queues the magnitude.
`default_nettype none

module itoa_front
    import itoa_pkg::*;
(
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic [1:0]  s_axis_tuser,
    output logic             push,
    output job_t             push_data,
    input  wire logic        full
);

    req_type_t req;
    logic      neg;

    // Take a transaction whenever the queue has room
    assign s_axis_tready = !full;
    assign req           = req_type_t'(s_axis_tuser);

    // Classify: drop the unused mode, split off the sign in signed mode
    always_comb
    begin
        neg            = (req == REQ_SDEC) && s_axis_tdata[31];
        push           = s_axis_tvalid && !full && (req != REQ_NONE);
        push_data.hex  = (req == REQ_HEX);
        push_data.neg  = neg;
        push_data.mag  = neg ? (~s_axis_tdata + 32'd1) : s_axis_tdata;
    end

endmodule

`default_nettype wire

// File: src/itoa_conv.sv
// Digit generator: one digit per cycle, least significant first.
`default_nettype none

module itoa_conv
    import itoa_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  job_valid,
    input  wire job_t  job_data,
    output logic       job_pop,
    output logic       res_valid,
    output conv_t      res_data,
    input  wire logic  res_ready
);

    conv_state_t       state_reg, state_next;
    logic [31:0]       num_reg, num_next;
    logic              hex_reg, hex_next;
    logic              neg_reg, neg_next;
    digit_vec_t        digits_reg, digits_next;
    logic [CNT_W-1:0]  ndig_reg, ndig_next;

    logic [63:0]       prod;
    logic [QUOT_W-1:0] quot10;
    logic [31:0]       times10;
    logic [31:0]       dec_rest;
    logic [3:0]        digit;
    logic [31:0]       quot;
    logic              step;

    // Divide by ten through the reciprocal, or by sixteen through a shift
    assign prod     = {32'd0, num_reg} * {32'd0, RECIP10};
    assign quot10   = prod[63:RECIP_SHIFT];
    assign times10  = {quot10, 3'b000} + {2'b00, quot10, 1'b0};
    assign dec_rest = num_reg - times10;
    assign digit    = hex_reg ? num_reg[3:0] : dec_rest[3:0];
    assign quot     = hex_reg ? {4'd0, num_reg[31:4]} : {3'd0, quot10};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CV_IDLE:
            begin
                if (job_valid)
                begin
                    state_next = CV_RUN;
                end
            end
            CV_RUN:
            begin
                if (quot == '0)
                begin
                    state_next = CV_DONE;
                end
            end
            CV_DONE:
            begin
                if (res_ready)
                begin
                    state_next = CV_IDLE;
                end
            end
            default:
            begin
                state_next = CV_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        job_pop   = 1'b0;
        res_valid = 1'b0;
        step      = 1'b0;
        unique case (state_reg)
            CV_IDLE: job_pop   = job_valid;
            CV_RUN:  step      = 1'b1;
            CV_DONE: res_valid = 1'b1;
            default: job_pop   = 1'b0;
        endcase
    end

    // Load a job, then shift each new digit in at slot 0
    always_comb
    begin
        num_next    = num_reg;
        hex_next    = hex_reg;
        neg_next    = neg_reg;
        digits_next = digits_reg;
        ndig_next   = ndig_reg;
        if (job_pop)
        begin
            num_next  = job_data.mag;
            hex_next  = job_data.hex;
            neg_next  = job_data.neg;
            ndig_next = '0;
        end
        else if (step)
        begin
            num_next       = quot;
            digits_next[0] = digit;
            for (int i = 1; i < MAX_DIGITS; i++)
            begin
                digits_next[i] = digits_reg[i-1];
            end
            ndig_next = ndig_reg + 1'b1;
        end
    end

    assign res_data.digits = digits_reg;
    assign res_data.ndig   = ndig_reg;
    assign res_data.neg    = neg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg    <= num_next;
        hex_reg    <= hex_next;
        neg_reg    <= neg_next;
        digits_reg <= digits_next;
        ndig_reg   <= ndig_next;
    end

endmodule

`default_nettype wire

// File: src/itoa_emit.sv
// Character emitter: sign, then digits most significant first, through an output register.
`default_nettype none

module itoa_emit
    import itoa_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire conv_t      in_data,
    output logic            in_ready,
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata,
    output logic            m_axis_tlast
);

    emit_state_t      state_reg, state_next;
    digit_vec_t       digits_reg, digits_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_char_reg, out_char_next;
    logic             out_last_reg, out_last_next;

    logic             out_free;
    logic             load;
    logic             emit_fire;
    logic             emit_digit;
    logic [7:0]       emit_char;
    logic             emit_last;
    logic             final_digit;

    assign out_free    = !out_valid_reg || m_axis_tready;
    assign final_digit = (cnt_reg == CNT_W'(1));
    assign load        = in_valid && in_ready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            EM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = in_data.neg ? EM_SIGN : EM_DIGITS;
                end
            end
            EM_SIGN:
            begin
                if (out_free)
                begin
                    state_next = EM_DIGITS;
                end
            end
            EM_DIGITS:
            begin
                if (out_free && final_digit)
                begin
                    if (in_valid)
                    begin
                        state_next = in_data.neg ? EM_SIGN : EM_DIGITS;
                    end
                    else
                    begin
                        state_next = EM_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready   = 1'b0;
        emit_fire  = 1'b0;
        emit_digit = 1'b0;
        emit_char  = CHAR_MINUS;
        emit_last  = 1'b0;
        unique case (state_reg)
            EM_IDLE:
            begin
                in_ready = 1'b1;
            end
            EM_SIGN:
            begin
                emit_fire = out_free;
            end
            EM_DIGITS:
            begin
                emit_fire  = out_free;
                emit_digit = out_free;
                emit_char  = digit_glyph(digits_reg[0]);
                emit_last  = final_digit;
                in_ready   = final_digit && out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Load a digit string, or shift the emitted digit out of slot 0
    always_comb
    begin
        digits_next = digits_reg;
        cnt_next    = cnt_reg;
        if (load)
        begin
            digits_next = in_data.digits;
            cnt_next    = in_data.ndig;
        end
        else if (emit_digit)
        begin
            for (int i = 0; i < MAX_DIGITS - 1; i++)
            begin
                digits_next[i] = digits_reg[i+1];
            end
            digits_next[MAX_DIGITS-1] = '0;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Hold the output register until the transaction completes
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        priority if (emit_fire)
        begin
            out_valid_next = 1'b1;
            out_char_next  = emit_char;
            out_last_next  = emit_last;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_char_reg;
    assign m_axis_tlast  = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg   <= digits_next;
        cnt_reg      <= cnt_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

endmodule

`default_nettype wire

// File: src/itoa_checker.sv
// Port-level checks on the formatter's character stream, bound to the top level.
`default_nettype none

module itoa_checker
    import itoa_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [31:0] s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [7:0]  m_axis_tdata,
    input wire logic        m_axis_tlast
);

    logic out_xfer;
    logic in_xfer;
    logic start_reg;
    logic lead_reg;

    assign out_xfer = m_axis_tvalid && m_axis_tready;
    assign in_xfer  = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
                      && (s_axis_tuser == s_axis_tuser);

    // Track the first character of a number, and the first digit after any sign
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b1;
            lead_reg  <= 1'b1;
        end
        else if (out_xfer)
        begin
            start_reg <= m_axis_tlast;
            lead_reg  <= m_axis_tlast || (m_axis_tdata == CHAR_MINUS);
        end
    end

    // A stalled character holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output character changed while stalled");

    // Only digits, a to f and the minus sign leave the block
    a_charset: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata >= CHAR_ZERO) && (m_axis_tdata <= CHAR_ZERO + 8'd9)) ||
            ((m_axis_tdata >= CHAR_A) && (m_axis_tdata <= CHAR_A + 8'd5)) ||
            (m_axis_tdata == CHAR_MINUS))
        else $error("illegal output character");

    // A minus sign opens a number and never ends it
    a_sign: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata == CHAR_MINUS) |-> start_reg && !m_axis_tlast)
        else $error("misplaced minus sign");

    // A leading zero is only the whole number zero
    a_lead_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && lead_reg && (m_axis_tdata == CHAR_ZERO) |->
            m_axis_tlast && start_reg)
        else $error("leading zero emitted");

    // Nothing comes out of an empty, freshly reset block
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_axis_tvalid || in_xfer)
        else $error("output without input after reset");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (.*);

`default_nettype wire

// File: sim/tb_integer_to_ascii_formatter.sv
// Self-checking testbench for the integer to ASCII formatter stream block.
`timescale 1ns / 1ps

module tb_integer_to_ascii_formatter;
    import itoa_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 5;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 30;
    localparam int HOLD_CYCLES   = 200;

    // One expected character on the output stream
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } expected_char_t;

    // Predicts the characters of each accepted number and checks the output
    class char_board;
        expected_char_t pending_chars[$];
        int             errors;

        function new();
            errors = 0;
        endfunction

        function int outstanding();
            return pending_chars.size();
        endfunction

        // Expand one accepted number into its characters, most significant first
        function void note_request(input logic [31:0] value, input req_type_t mode);
            logic [31:0] mag;
            logic [31:0] radix;
            logic [3:0]  d;
            logic [7:0]  digits[$];
            expected_char_t item;
            if (mode == REQ_NONE)
            begin
                return;
            end
            radix = (mode == REQ_HEX) ? 32'd16 : 32'd10;
            mag   = value;
            if (mode == REQ_SDEC && value[31])
            begin
                item.ch   = CHAR_MINUS;
                item.last = 1'b0;
                pending_chars.push_back(item);
                mag = -value;
            end
            do
            begin
                d   = 4'(mag % radix);
                mag = mag / radix;
                digits.push_front((d < 4'd10) ? CHAR_ZERO + {4'd0, d}
                                              : CHAR_A + {4'd0, d} - 8'd10);
            end
            while (mag != 0);
            foreach (digits[i])
            begin
                item.ch   = digits[i];
                item.last = (i == digits.size() - 1);
                pending_chars.push_back(item);
            end
        endfunction

        // Compare one output transaction with the oldest expected character
        function void check_char(input logic [7:0] ch, input logic last);
            expected_char_t want;
            if (pending_chars.size() == 0)
            begin
                $display("%0t: unexpected character %h last %b", $time, ch, last);
                errors++;
                return;
            end
            want = pending_chars.pop_front();
            if (ch !== want.ch)
            begin
                $display("%0t: ascii_char expected %h actual %h", $time, want.ch, ch);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_char expected %b actual %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    char_board sb;
    int        src_idle_pct;
    int        dst_idle_pct;
    int        rx_hold;
    int        cycle_count;

    integer_to_ascii_formatter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Generate the clock
    initial clk = 1'b0;
    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_integer_to_ascii_formatter failed");
            $finish;
        end
    end

    // Drive output backpressure: a long hold first if requested, else random stalls
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                m_axis_tready = 1'b0;
                rx_hold--;
            end
            else
            begin
                m_axis_tready = ($urandom_range(99) >= dst_idle_pct);
            end
        end
    end

    // Check every character transaction
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sb.check_char(m_axis_tdata, m_axis_tlast);
        end
    end

    // Offer one number, idling at random first, and hold it until accepted
    task automatic send_number(input logic [31:0] value, input req_type_t mode);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = value;
        s_axis_tuser  = mode;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        sb.note_request(value, mode);
        @(negedge clk);
    endtask

    // Stop offering and wait until every expected character has left
    task automatic drain_characters();
        s_axis_tvalid = 1'b0;
        while (sb.outstanding() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Pick a value that favors digit-count boundaries and short numbers
    function automatic logic [31:0] pick_value(input req_type_t mode);
        logic [31:0] p;
        int          k;
        case ($urandom_range(9))
            0, 1:    return $urandom_range(0, 99);
            2:
            begin
                p = 32'd1;
                k = (mode == REQ_HEX) ? $urandom_range(7) : $urandom_range(9);
                repeat (k)
                begin
                    p = (mode == REQ_HEX) ? p << 4 : p * 32'd10;
                end
                return p + 32'($urandom_range(2)) - 32'd1;
            end
            3:       return $urandom_range(0, 16'hFFFF);
            4:       return 32'hFFFF_FFFF >> $urandom_range(31);
            5:       return -32'($urandom_range(1, 1000));
            default: return $urandom();
        endcase
    endfunction

    // Send a phase of random numbers; ignored mode-3 items are not counted
    task automatic send_random_numbers(input int count);
        req_type_t mode;
        int        sent;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 5)
            begin
                mode = REQ_NONE;
            end
            else
            begin
                mode = req_type_t'($urandom_range(2));
                sent++;
            end
            send_number(pick_value(mode), mode);
        end
    endtask

    initial
    begin
        sb            = new();
        rx_hold       = 0;
        src_idle_pct  = 27;
        dst_idle_pct  = 46;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        rst_n         = 1'b0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, each mode, zero, sign and the most negative value
        send_number(32'd0, REQ_UDEC);
        send_number(32'd1, REQ_UDEC);
        send_number(32'd9, REQ_UDEC);
        send_number(32'd10, REQ_UDEC);
        send_number(32'd999999999, REQ_UDEC);
        send_number(32'd1000000000, REQ_UDEC);
        send_number(32'hFFFF_FFFF, REQ_UDEC);
        send_number(32'd0, REQ_HEX);
        send_number(32'hF, REQ_HEX);
        send_number(32'h10, REQ_HEX);
        send_number(32'h89AB_CDEF, REQ_HEX);
        send_number(32'h1000_0000, REQ_HEX);
        send_number(32'hFFFF_FFFF, REQ_HEX);
        send_number(32'd0, REQ_SDEC);
        send_number(32'd1, REQ_SDEC);
        send_number(32'hFFFF_FFFF, REQ_SDEC);
        send_number(32'hFFFF_FFF6, REQ_SDEC);
        send_number(32'h7FFF_FFFF, REQ_SDEC);
        send_number(32'h8000_0000, REQ_SDEC);
        send_number(32'hC465_3600, REQ_SDEC);
        send_number(32'h1234_5678, REQ_NONE);
        send_number(32'd7, REQ_UDEC);
        drain_characters();

        // Random, sender idles less than receiver stalls
        send_random_numbers(120);
        drain_characters();

        // Random, roles swapped
        src_idle_pct = 46;
        dst_idle_pct = 27;
        send_random_numbers(120);
        drain_characters();

        // Full rate, starting with a long output hold so the input backs up
        src_idle_pct = 0;
        dst_idle_pct = 0;
        rx_hold      = HOLD_CYCLES;
        send_random_numbers(120);
        drain_characters();

        // Let any stray output show up before closing
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.outstanding() != 0)
        begin
            $display("%0t: %0d characters never arrived", $time, sb.outstanding());
            sb.errors++;
        end
        if (sb.errors == 0)
        begin
            $display("tb_integer_to_ascii_formatter passed");
        end
        else
        begin
            $display("tb_integer_to_ascii_formatter failed");
        end
        $finish;
    end

endmodule

// File: files.f
src/itoa_pkg.sv
src/itoa_fifo.sv
src/itoa_front.sv
src/itoa_conv.sv
src/itoa_emit.sv
src/integer_to_ascii_formatter.sv
src/itoa_checker.sv
sim/tb_integer_to_ascii_formatter.sv
